>>> hdl/mlet_pkg.sv
// shared types, opcodes and register indexes for the line envelope tree
// no dependencies; used by mlet_node_ram and min_line_envelope_tree
`default_nettype none

package mlet_pkg;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [63:0] val_t;

    localparam logic [1:0] OP_FULL  = 2'd0;
    localparam logic [1:0] OP_SEG   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic REG_LO = 1'b0;
    localparam logic REG_HI = 1'b1;

    localparam coord_t LO_RESET = 32'sd0;
    localparam coord_t HI_RESET = 32'sd1023;

    localparam val_t VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic   occ;
        coord_t slope;
        coord_t icpt;
    } node_t;

    // split point l + (r - l) / 2, with r >= l
    function automatic coord_t mid_point(input coord_t l, input coord_t r);
        logic signed [32:0] d;
        logic signed [32:0] s;
        d = $signed({r[31], r}) - $signed({l[31], l});
        s = $signed({l[31], l}) + (d >>> 1);
        return s[31:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/mlet_node_ram.sv
// node store: one line and an occupied mark per tree node
// single write port, one registered read port; depends on mlet_pkg
`default_nettype none

module mlet_node_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire                   clk,
    input  wire                   we,
    input  wire [AW-1:0]          waddr,
    input  mlet_pkg::node_t       wdata,
    input  wire [AW-1:0]          raddr,
    output mlet_pkg::node_t       rdata
);

    mlet_pkg::node_t mem [DEPTH];
    mlet_pkg::node_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/min_line_envelope_tree.sv
// lower envelope of lines over an integer range, kept as a heap-indexed tree
// depends on mlet_pkg and mlet_node_ram
//
//  port group        direction  handshake
//  cfg_we/index/data in         written at any edge with cfg_we high
//  start + fields    in         item taken when start high and busy low
//  done + results    out        one-cycle strobe, no back-pressure
//
// full insert: per occupied node met on the way down, a read, evaluation at
// both ends and the midpoint, and a decision; segment insert: the SEG state
// per visited node and the POP state per stack pop, plus the descents from
// each canonical node; query: read, multiply and add per level. one shared
// 32x32 multiplier sets the per-level cost. every item gives exactly one done
// strobe. after reset a clearing pass empties the NODE_COUNT nodes, busy high.
`default_nettype none

module min_line_envelope_tree #(
    parameter int NODE_COUNT = 2048
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire [31:0]           cfg_data,
    input  wire                  start,
    output logic                 busy,
    input  wire [1:0]            opcode,
    input  wire signed [31:0]    slope,
    input  wire signed [31:0]    intercept,
    input  wire signed [31:0]    seg_lo,
    input  wire signed [31:0]    seg_hi,
    input  wire signed [31:0]    query_x,
    output logic                 done,
    output logic signed [63:0]   min_value,
    output logic                 none_found
);

    localparam int AW  = $clog2(NODE_COUNT);
    localparam int NW  = AW + 1;
    localparam int SD  = NW;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    localparam logic [NW-1:0] IDX_END  = NW'(NODE_COUNT);
    localparam logic [NW-1:0] IDX_ROOT = NW'(1);
    localparam logic [AW-1:0] CLR_LAST = AW'(NODE_COUNT - 1);
    localparam logic [2:0]    EV_LAST  = 3'd6;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_SEG   = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_LRD   = 4'd5;
    localparam logic [3:0] S_LWAIT = 4'd6;
    localparam logic [3:0] S_LEVAL = 4'd7;
    localparam logic [3:0] S_LDEC  = 4'd8;
    localparam logic [3:0] S_QRD   = 4'd9;
    localparam logic [3:0] S_QMUL  = 4'd10;
    localparam logic [3:0] S_QADD  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    typedef struct packed {
        logic [NW-1:0]    idx;
        mlet_pkg::coord_t l;
        mlet_pkg::coord_t r;
    } frame_t;

    logic [3:0]        state_reg;
    logic [AW-1:0]     clr_reg;
    mlet_pkg::coord_t  lo_reg, hi_reg;
    logic [1:0]        op_reg;
    mlet_pkg::coord_t  in_k_reg, in_b_reg, ql_reg, qr_reg, qx_reg;

    logic [NW-1:0]     sg_idx_reg;
    mlet_pkg::coord_t  sg_l_reg, sg_r_reg;
    frame_t            stk_reg [SD];
    logic [SPW-1:0]    sp_reg;

    logic [NW-1:0]     pl_idx_reg;
    mlet_pkg::coord_t  pl_l_reg, pl_r_reg, pl_k_reg, pl_b_reg;
    mlet_pkg::coord_t  cur_k_reg, cur_b_reg;
    logic [2:0]        ev_reg;
    mlet_pkg::val_t    vals_reg [6];

    logic [NW-1:0]     q_idx_reg;
    mlet_pkg::coord_t  q_l_reg, q_r_reg;
    logic              q_occ_reg;
    mlet_pkg::val_t    best_reg;
    logic              found_reg;

    mlet_pkg::val_t    prod_reg;
    mlet_pkg::coord_t  pb_reg;

    logic              done_reg;
    mlet_pkg::val_t    min_value_reg;
    logic              none_found_reg;

    mlet_pkg::coord_t  mul_a, mul_x, mul_b;
    mlet_pkg::val_t    sum;
    mlet_pkg::coord_t  sg_mid, pl_mid, q_mid;
    logic              bounds_ok, x_in;
    logic              same_side, swap, go_left;
    logic [3:0]        line_exit;
    logic [NW-1:0]     q_next_idx;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    mlet_pkg::node_t   mem_wdata, mem_rdata;

    mlet_node_ram #(
        .DEPTH (NODE_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign sg_mid    = mlet_pkg::mid_point(sg_l_reg, sg_r_reg);
    assign pl_mid    = mlet_pkg::mid_point(pl_l_reg, pl_r_reg);
    assign q_mid     = mlet_pkg::mid_point(q_l_reg, q_r_reg);
    assign bounds_ok = lo_reg <= hi_reg;
    assign x_in      = (qx_reg >= lo_reg) && (qx_reg <= hi_reg);
    assign sum       = prod_reg + {{32{pb_reg[31]}}, pb_reg};
    assign line_exit = (op_reg == mlet_pkg::OP_SEG) ? S_POP : S_FIN;
    assign q_next_idx = (qx_reg <= q_mid) ? (q_idx_reg << 1) : ((q_idx_reg << 1) | IDX_ROOT);

    // vals: 0 stored@l 1 stored@r 2 new@l 3 new@r 4 stored@md 5 new@md
    assign same_side = (vals_reg[0] <= vals_reg[2]) == (vals_reg[1] <= vals_reg[3]);
    assign swap      = vals_reg[5] < vals_reg[4];
    assign go_left   = swap ? (vals_reg[0] < vals_reg[2]) : (vals_reg[2] < vals_reg[0]);

    always_comb
    begin
        mul_a = cur_k_reg;
        mul_x = pl_l_reg;
        mul_b = cur_b_reg;
        if (state_reg == S_QMUL)
        begin
            mul_a = mem_rdata.slope;
            mul_x = qx_reg;
            mul_b = mem_rdata.icpt;
        end
        else
        begin
            case (ev_reg)
                3'd1:    begin mul_a = cur_k_reg; mul_x = pl_r_reg; mul_b = cur_b_reg; end
                3'd2:    begin mul_a = pl_k_reg;  mul_x = pl_l_reg; mul_b = pl_b_reg;  end
                3'd3:    begin mul_a = pl_k_reg;  mul_x = pl_r_reg; mul_b = pl_b_reg;  end
                3'd4:    begin mul_a = cur_k_reg; mul_x = pl_mid;   mul_b = cur_b_reg; end
                3'd5:    begin mul_a = pl_k_reg;  mul_x = pl_mid;   mul_b = pl_b_reg;  end
                default: begin mul_a = cur_k_reg; mul_x = pl_l_reg; mul_b = cur_b_reg; end
            endcase
        end
    end

    always_comb
    begin
        mem_raddr = (state_reg == S_QRD) ? q_idx_reg[AW-1:0] : pl_idx_reg[AW-1:0];
        mem_waddr = pl_idx_reg[AW-1:0];
        mem_wdata = '{occ: 1'b1, slope: pl_k_reg, icpt: pl_b_reg};
        mem_we    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            S_LWAIT: mem_we = !mem_rdata.occ;
            S_LDEC:  mem_we = same_side ? (vals_reg[2] < vals_reg[0]) : swap;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_x;
        pb_reg   <= mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            lo_reg    <= mlet_pkg::LO_RESET;
            hi_reg    <= mlet_pkg::HI_RESET;
            sp_reg    <= '0;
            done_reg  <= 1'b0;
            ev_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mlet_pkg::REG_LO: lo_reg <= cfg_data;
                    mlet_pkg::REG_HI: hi_reg <= cfg_data;
                    default:          lo_reg <= lo_reg;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= opcode;
                        in_k_reg  <= slope;
                        in_b_reg  <= intercept;
                        ql_reg    <= seg_lo;
                        qr_reg    <= seg_hi;
                        qx_reg    <= query_x;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    best_reg   <= mlet_pkg::VAL_MAX;
                    found_reg  <= 1'b0;
                    sp_reg     <= '0;
                    pl_k_reg   <= in_k_reg;
                    pl_b_reg   <= in_b_reg;
                    pl_idx_reg <= IDX_ROOT;
                    pl_l_reg   <= lo_reg;
                    pl_r_reg   <= hi_reg;
                    sg_idx_reg <= IDX_ROOT;
                    sg_l_reg   <= lo_reg;
                    sg_r_reg   <= hi_reg;
                    q_idx_reg  <= IDX_ROOT;
                    q_l_reg    <= lo_reg;
                    q_r_reg    <= hi_reg;
                    state_reg  <= S_FIN;
                    if (bounds_ok)
                    begin
                        case (op_reg)
                            mlet_pkg::OP_FULL:  state_reg <= S_LRD;
                            mlet_pkg::OP_SEG:   state_reg <= S_SEG;
                            mlet_pkg::OP_QUERY: state_reg <= x_in ? S_QRD : S_FIN;
                            default:            state_reg <= S_FIN;
                        endcase
                    end
                end
                S_SEG:
                begin
                    if (sg_idx_reg >= IDX_END || qr_reg < sg_l_reg || sg_r_reg < ql_reg)
                    begin
                        state_reg <= S_POP;
                    end
                    else if (sg_l_reg < ql_reg || sg_r_reg > qr_reg)
                    begin
                        // right half waits on the stack, walk the left half now
                        stk_reg[sp_reg[SIW-1:0]] <= '{idx: (sg_idx_reg << 1) | IDX_ROOT,
                                                     l: sg_mid + 32'sd1, r: sg_r_reg};
                        sp_reg     <= sp_reg + 1'b1;
                        sg_idx_reg <= sg_idx_reg << 1;
                        sg_r_reg   <= sg_mid;
                    end
                    else
                    begin
                        pl_idx_reg <= sg_idx_reg;
                        pl_l_reg   <= sg_l_reg;
                        pl_r_reg   <= sg_r_reg;
                        pl_k_reg   <= in_k_reg;
                        pl_b_reg   <= in_b_reg;
                        state_reg  <= S_LRD;
                    end
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        sp_reg     <= sp_reg - 1'b1;
                        sg_idx_reg <= stk_reg[SIW'(sp_reg - 1'b1)].idx;
                        sg_l_reg   <= stk_reg[SIW'(sp_reg - 1'b1)].l;
                        sg_r_reg   <= stk_reg[SIW'(sp_reg - 1'b1)].r;
                        state_reg  <= S_SEG;
                    end
                end
                S_LRD:
                begin
                    state_reg <= (pl_idx_reg >= IDX_END) ? line_exit : S_LWAIT;
                end
                S_LWAIT:
                begin
                    cur_k_reg <= mem_rdata.slope;
                    cur_b_reg <= mem_rdata.icpt;
                    ev_reg    <= '0;
                    state_reg <= mem_rdata.occ ? S_LEVAL : line_exit;
                end
                S_LEVAL:
                begin
                    // product issued at ev lands as a value in the next cycle
                    ev_reg <= ev_reg + 1'b1;
                    if (ev_reg != 3'd0)
                    begin
                        vals_reg[ev_reg - 3'd1] <= sum;
                    end
                    if (ev_reg == EV_LAST)
                    begin
                        state_reg <= S_LDEC;
                    end
                end
                S_LDEC:
                begin
                    if (same_side)
                    begin
                        state_reg <= line_exit;
                    end
                    else
                    begin
                        if (swap)
                        begin
                            pl_k_reg <= cur_k_reg;
                            pl_b_reg <= cur_b_reg;
                        end
                        if (go_left)
                        begin
                            pl_idx_reg <= pl_idx_reg << 1;
                            pl_r_reg   <= pl_mid;
                        end
                        else
                        begin
                            pl_idx_reg <= (pl_idx_reg << 1) | IDX_ROOT;
                            pl_l_reg   <= pl_mid + 32'sd1;
                        end
                        state_reg <= S_LRD;
                    end
                end
                S_QRD:
                begin
                    state_reg <= S_QMUL;
                end
                S_QMUL:
                begin
                    q_occ_reg <= mem_rdata.occ;
                    state_reg <= S_QADD;
                end
                S_QADD:
                begin
                    if (q_occ_reg)
                    begin
                        found_reg <= 1'b1;
                        if (sum < best_reg)
                        begin
                            best_reg <= sum;
                        end
                    end
                    if (q_l_reg == q_r_reg || q_next_idx >= IDX_END)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        q_idx_reg <= q_next_idx;
                        if (qx_reg <= q_mid)
                        begin
                            q_r_reg <= q_mid;
                        end
                        else
                        begin
                            q_l_reg <= q_mid + 32'sd1;
                        end
                        state_reg <= S_QRD;
                    end
                end
                S_FIN:
                begin
                    done_reg <= 1'b1;
                    if (op_reg == mlet_pkg::OP_QUERY)
                    begin
                        min_value_reg  <= best_reg;
                        none_found_reg <= !found_reg;
                    end
                    else
                    begin
                        min_value_reg  <= '0;
                        none_found_reg <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign min_value  = min_value_reg;
    assign none_found = none_found_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_FIN)
        else $error("result strobe without a finished item");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(SD))
        else $error("segment stack overflow");

    a_clear_writes_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> mem_we && !mem_wdata.occ)
        else $error("clearing pass wrote an occupied node");

    a_none_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && none_found_reg |-> min_value_reg == mlet_pkg::VAL_MAX)
        else $error("empty query did not report the maximum");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for min_line_envelope_tree: random and directed inserts and queries
// checked against a line envelope tree predictor; depends on mlet_pkg and the rtl
`timescale 1ns / 1ps

module tb;

    localparam int NODES = 2048;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class envelope_board;
        logic signed [31:0] lo_b, hi_b;
        logic signed [31:0] k_mem [NODES];
        logic signed [31:0] b_mem [NODES];
        bit occ_mem [NODES];
        mlet_pkg::val_t want_val [$];
        bit want_none [$];
        int errors;

        function void clear();
            lo_b = mlet_pkg::LO_RESET;
            hi_b = mlet_pkg::HI_RESET;
            for (int i = 0; i < NODES; i++)
            begin
                k_mem[i] = 0;
                b_mem[i] = 0;
                occ_mem[i] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(bit idx, logic [31:0] d);
            if (idx == mlet_pkg::REG_LO)
                lo_b = d;
            else
                hi_b = d;
        endfunction

        function mlet_pkg::val_t eval(longint k, longint b, longint x);
            return k * x + b;
        endfunction

        function void put_line(int idx, longint l, longint r, longint k, longint b);
            longint ck, cb, vlc, vrc, vln, vrn, md, t;
            while (idx < NODES)
            begin
                if (!occ_mem[idx])
                begin
                    occ_mem[idx] = 1;
                    k_mem[idx] = 32'(k);
                    b_mem[idx] = 32'(b);
                    return;
                end
                ck = k_mem[idx];
                cb = b_mem[idx];
                vlc = eval(ck, cb, l);
                vrc = eval(ck, cb, r);
                vln = eval(k, b, l);
                vrn = eval(k, b, r);
                if ((vlc <= vln) == (vrc <= vrn))
                begin
                    if (vln < vlc)
                    begin
                        k_mem[idx] = 32'(k);
                        b_mem[idx] = 32'(b);
                    end
                    return;
                end
                md = l + (r - l) / 2;
                if (eval(k, b, md) < eval(ck, cb, md))
                begin
                    k_mem[idx] = 32'(k);
                    b_mem[idx] = 32'(b);
                    k = ck;
                    b = cb;
                    t = vln;
                    vln = vlc;
                    vlc = t;
                end
                if (vln < vlc)
                begin
                    idx = 2 * idx;
                    r = md;
                end
                else
                begin
                    idx = 2 * idx + 1;
                    l = md + 1;
                end
            end
        endfunction

        function void put_seg(int idx, longint l, longint r, longint ql, longint qr,
                              longint k, longint b);
            longint md;
            if (idx >= NODES || qr < l || r < ql)
                return;
            if (l < ql || r > qr)
            begin
                md = l + (r - l) / 2;
                put_seg(2 * idx, l, md, ql, qr, k, b);
                put_seg(2 * idx + 1, md + 1, r, ql, qr, k, b);
                return;
            end
            put_line(idx, l, r, k, b);
        endfunction

        // note an accepted item and queue its expected result
        function void note_item(logic [1:0] op, longint k, longint b, longint ql,
                                longint qr, longint x);
            longint lo, hi, l, r, md, v;
            mlet_pkg::val_t best;
            bit found;
            int idx;
            lo = lo_b;
            hi = hi_b;
            best = 0;
            found = 1;
            if (op == mlet_pkg::OP_FULL && lo <= hi)
                put_line(1, lo, hi, k, b);
            else if (op == mlet_pkg::OP_SEG && lo <= hi)
                put_seg(1, lo, hi, ql, qr, k, b);
            else if (op == mlet_pkg::OP_QUERY)
            begin
                best = mlet_pkg::VAL_MAX;
                found = 0;
                if (lo <= hi && x >= lo && x <= hi)
                begin
                    idx = 1;
                    l = lo;
                    r = hi;
                    while (idx < NODES)
                    begin
                        if (occ_mem[idx])
                        begin
                            v = eval(k_mem[idx], b_mem[idx], x);
                            if (!found || v < best)
                                best = v;
                            found = 1;
                        end
                        if (l == r)
                            break;
                        md = l + (r - l) / 2;
                        if (x <= md)
                        begin
                            r = md;
                            idx = 2 * idx;
                        end
                        else
                        begin
                            l = md + 1;
                            idx = 2 * idx + 1;
                        end
                    end
                end
            end
            want_val.push_back(best);
            want_none.push_back(!found);
        endfunction

        function void check_result(mlet_pkg::val_t val, bit none);
            mlet_pkg::val_t ev;
            bit en;
            if (want_val.size() == 0)
            begin
                $display("%0t: unexpected result val=%0d none=%0b", $time, val, none);
                errors++;
                return;
            end
            ev = want_val.pop_front();
            en = want_none.pop_front();
            if (ev !== val)
            begin
                $display("%0t: min_value expected %0d actual %0d", $time, ev, val);
                errors++;
            end
            if (en !== none)
            begin
                $display("%0t: none_found expected %0b actual %0b", $time, en, none);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [31:0] cfg_data = 0;
    logic start = 0;
    logic [1:0] opcode = 0;
    logic signed [31:0] slope = 0, intercept = 0, seg_lo = 0, seg_hi = 0, query_x = 0;
    wire busy, done, none_found;
    wire signed [63:0] min_value;
    int idle_pct = 0;
    envelope_board board;

    min_line_envelope_tree i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .opcode(opcode),
        .slope(slope), .intercept(intercept), .seg_lo(seg_lo), .seg_hi(seg_hi),
        .query_x(query_x), .done(done), .min_value(min_value),
        .none_found(none_found)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            board.check_result(min_value, none_found);

    task automatic write_reg(bit idx, logic [31:0] d);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 0;
        board.set_reg(idx, d);
    endtask

    task automatic send(logic [1:0] op, logic [31:0] k, logic [31:0] b,
                        logic [31:0] ql, logic [31:0] qr, logic [31:0] x);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        start <= 1;
        opcode <= op;
        slope <= k;
        intercept <= b;
        seg_lo <= ql;
        seg_hi <= qr;
        query_x <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(op, $signed(k), $signed(b), $signed(ql), $signed(qr),
                        $signed(x));
        start <= 0;
        // the block is busy with the item here, so start is dropped before the next send
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.want_val.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] near(int lo, int hi);
        int span;
        span = hi - lo;
        if ($urandom_range(9) == 0)
            return $urandom;
        return lo - 4 + $urandom_range(span + 8);
    endfunction

    // small coefficients make ties and crossings likely, wide ones stress products
    function automatic logic [31:0] coef();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2000)) - 1000;
            default: return $signed($urandom_range(40)) - 20;
        endcase
    endfunction

    task automatic random_phase(int n, int lo, int hi, int pct);
        int sel;
        logic [31:0] a, c;
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            a = near(lo, hi);
            c = near(lo, hi);
            if (sel < 25)
                send(mlet_pkg::OP_FULL, coef(), coef(), $urandom, $urandom, $urandom);
            else if (sel < 50)
                send(mlet_pkg::OP_SEG, coef(), coef(), a, c, $urandom);
            else if (sel < 97)
                send(mlet_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom, a);
            else
                send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        drain();
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        // directed: empty tree, extremes, every opcode, bounds edges
        send(mlet_pkg::OP_QUERY, 0, 0, 0, 0, 5);
        send(mlet_pkg::OP_FULL, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send(mlet_pkg::OP_FULL, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        send(mlet_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        send(mlet_pkg::OP_QUERY, 0, 0, 0, 0, 1023);
        send(mlet_pkg::OP_QUERY, 0, 0, 0, 0, 1024);
        send(mlet_pkg::OP_QUERY, 0, 0, 0, 0, -1);
        send(mlet_pkg::OP_SEG, -3, 7, 100, 300, 0);
        send(mlet_pkg::OP_SEG, 5, 5, 300, 100, 0);
        send(mlet_pkg::OP_SEG, 5, 5, 2000, 3000, 0);
        send(mlet_pkg::OP_SEG, 1, -50, 512, 512, 0);
        send(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
        send(mlet_pkg::OP_QUERY, 0, 0, 0, 0, 512);
        send(mlet_pkg::OP_QUERY, 0, 0, 0, 0, 200);
        send(mlet_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'h7FFF_FFFF);
        drain();
        random_phase(350, 0, 1023, 0);
        // reversed bounds
        write_reg(mlet_pkg::REG_LO, 50);
        write_reg(mlet_pkg::REG_HI, 10);
        random_phase(60, 10, 50, 70);
        // extreme negative corner, span beyond the store
        write_reg(mlet_pkg::REG_LO, 32'h8000_0000);
        write_reg(mlet_pkg::REG_HI, 32'h8000_0000 + 5000);
        random_phase(300, -2147483647 - 1, -2147483647 + 4999, 6);
        // extreme positive corner, single point
        write_reg(mlet_pkg::REG_LO, 32'h7FFF_FFFF);
        write_reg(mlet_pkg::REG_HI, 32'h7FFF_FFFF);
        random_phase(60, 2147483640, 2147483646, 0);
        // small range, dense collisions
        write_reg(mlet_pkg::REG_LO, -20);
        write_reg(mlet_pkg::REG_HI, 20);
        random_phase(350, -20, 20, 70);
        write_reg(mlet_pkg::REG_LO, -400);
        write_reg(mlet_pkg::REG_HI, 623);
        random_phase(330, -400, 623, 0);
        write_reg(mlet_pkg::REG_LO, 32'h8000_0000);
        write_reg(mlet_pkg::REG_HI, 32'h7FFF_FFFF);
        random_phase(300, -1000, 1000, 6);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("FAIL");
        $finish;
    end
endmodule

>>> files.f
hdl/mlet_pkg.sv
hdl/mlet_node_ram.sv
hdl/min_line_envelope_tree.sv
tb/sv/tb.sv
